FILE: src/obup_pkg.sv
// ============================================================================
// obup_pkg
// Shared types and constants of the unit size-and-header parser: transaction
// structs, the event codes that pass from front to back, and field widths.
// ============================================================================
`default_nettype none

package obup_pkg;

    // Fixed field widths.
    localparam int TYPE_BITS     = 5;
    localparam int TEMPORAL_BITS = 2;
    localparam int ML_OUT_BITS   = 3;
    localparam int XL_OUT_BITS   = 5;
    localparam int SIZE_BITS     = 32;
    localparam int COUNT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    // Defaults for the top-level parameters.
    localparam int MAIN_LAYER_BITS_DEF = 3;
    localparam int EXT_LAYER_BITS_DEF  = 5;
    localparam int MAX_SIZE_BYTES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // A size byte's seven value bits shifted by up to seven groups.
    localparam int PART_BITS  = 7 + 7 * 7;
    localparam int SHIFT_BITS = 6;

    // Bit positions inside the header byte.
    localparam int TYPE_MSB = 6;
    localparam int TL_LSB   = 8 - 1 - TYPE_BITS - TEMPORAL_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLOBAL_TYPE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLOBAL_XLAYER = 2'd1;

    // Result status codes.
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_CORRUPT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_BITS-1:0] GLOBAL_TYPE_RST   = 5'd0;
    localparam logic [CFG_DATA_BITS-1:0] GLOBAL_XLAYER_RST = 5'd31;

    // Input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic       last_byte;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic                   status;
        logic                   extension_present;
        logic [TYPE_BITS-1:0]   unit_type;
        logic [TEMPORAL_BITS-1:0] temporal_layer;
        logic [ML_OUT_BITS-1:0] main_layer;
        logic [XL_OUT_BITS-1:0] extended_layer;
        logic [SIZE_BITS-1:0]   payload_length;
        logic [COUNT_BITS-1:0]  consumed_count;
    } out_t;

    // Byte classes decided by the front end.
    typedef enum logic [2:0] {
        EV_SIZE,
        EV_HDR_SAVE,
        EV_HDR_FINAL,
        EV_EXT,
        EV_CORRUPT
    } ev_kind_t;

    // Event passed from front to back. For a size byte, cnt is the number of
    // size bytes before it; for a header or extension byte, the total.
    typedef struct packed {
        ev_kind_t              kind;
        logic [7:0]            data;
        logic [COUNT_BITS-1:0] cnt;
    } ev_t;

endpackage

`default_nettype wire

FILE: src/obup_fifo.sv
// ============================================================================
// obup_fifo
// Small register queue with full and empty flags; the head entry is shown
// on the read port while the queue is not empty.
// ============================================================================
`default_nettype none

module obup_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FullCnt);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/obup_front.sv
// ============================================================================
// obup_front
// Parse front end: tracks where each byte falls in the unit (size field,
// header byte, extension byte, ignored) and decides every corrupt case that
// the size field alone can show. Emits one event per meaningful byte.
// ============================================================================
`default_nettype none

module obup_front #(
    parameter int MAX_SIZE_BYTES = obup_pkg::MAX_SIZE_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  obup_pkg::in_t      item,
    output logic               ev_push,
    output obup_pkg::ev_t      ev
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SIZE,
        PH_HDR,
        PH_EXT
    } phase_t;

    localparam logic [obup_pkg::COUNT_BITS-1:0] MaxCnt =
        obup_pkg::COUNT_BITS'(MAX_SIZE_BYTES);

    phase_t                             phase_reg, phase_next;
    logic [obup_pkg::COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                               ovf_reg, ovf_next;
    phase_t                             phase_eff;
    logic [obup_pkg::COUNT_BITS-1:0]    cnt_eff;
    logic                               ovf_eff;
    logic [obup_pkg::COUNT_BITS-1:0]    cnt_inc;
    logic [obup_pkg::SHIFT_BITS-1:0]    shift_amt;
    logic [obup_pkg::PART_BITS-1:0]     part;
    logic                               part_ovf;
    logic                               ev_valid;
    obup_pkg::ev_kind_t                 ev_kind;

    // A start byte restarts the parse regardless of the current phase.
    assign phase_eff = item.start_req ? PH_SIZE : phase_reg;
    assign cnt_eff   = item.start_req ? '0 : cnt_reg;
    assign ovf_eff   = item.start_req ? 1'b0 : ovf_reg;
    assign cnt_inc   = cnt_eff + 1'b1;

    // Value bits of this size byte that land at or above bit 32.
    assign shift_amt = obup_pkg::SHIFT_BITS'(cnt_eff) * obup_pkg::SHIFT_BITS'(7);
    assign part      = {{(obup_pkg::PART_BITS - 7){1'b0}}, item.data_byte[6:0]} << shift_amt;
    assign part_ovf  = |part[obup_pkg::PART_BITS-1:obup_pkg::SIZE_BITS];

    // Byte classification and next phase.
    always_comb
    begin
        phase_next = phase_eff;
        cnt_next   = cnt_eff;
        ovf_next   = ovf_eff;
        ev_valid   = 1'b0;
        ev_kind    = obup_pkg::EV_SIZE;
        case (phase_eff)
            PH_SIZE:
            begin
                cnt_next = cnt_inc;
                ovf_next = ovf_eff | part_ovf;
                ev_valid = 1'b1;
                if (item.data_byte[7])
                begin
                    if (item.last_byte || (cnt_inc >= MaxCnt))
                    begin
                        ev_kind    = obup_pkg::EV_CORRUPT;
                        phase_next = PH_IDLE;
                    end
                end
                else if (ovf_eff || part_ovf || item.last_byte)
                begin
                    ev_kind    = obup_pkg::EV_CORRUPT;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_HDR;
                end
            end
            PH_HDR:
            begin
                ev_valid = 1'b1;
                if (item.data_byte[7])
                begin
                    if (item.last_byte)
                    begin
                        ev_kind    = obup_pkg::EV_CORRUPT;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        ev_kind    = obup_pkg::EV_HDR_SAVE;
                        phase_next = PH_EXT;
                    end
                end
                else
                begin
                    ev_kind    = obup_pkg::EV_HDR_FINAL;
                    phase_next = PH_IDLE;
                end
            end
            PH_EXT:
            begin
                ev_valid   = 1'b1;
                ev_kind    = obup_pkg::EV_EXT;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign ev_push  = accept && ev_valid;
    assign ev.kind  = ev_kind;
    assign ev.data  = item.data_byte;
    assign ev.cnt   = cnt_eff;

    // Parse phase and size field bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/obup_back.sv
// ============================================================================
// obup_back
// Parse back end: accumulates the size value from size-byte events, keeps
// the header byte, and builds the result transaction for a finished header
// or a corrupt unit.
// ============================================================================
`default_nettype none

module obup_back #(
    parameter int MAIN_LAYER_BITS = obup_pkg::MAIN_LAYER_BITS_DEF,
    parameter int EXT_LAYER_BITS  = obup_pkg::EXT_LAYER_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  obup_pkg::ev_t                            ev,
    input  wire logic                                ev_empty,
    output logic                                     ev_pop,
    input  wire logic [obup_pkg::TYPE_BITS-1:0]      global_type,
    input  wire logic [obup_pkg::XL_OUT_BITS-1:0]    global_xlayer,
    input  wire logic                                res_full,
    output logic                                     res_push,
    output obup_pkg::out_t                           res
);

    localparam int MlShift = 16 - MAIN_LAYER_BITS;
    localparam int XlShift = 16 - MAIN_LAYER_BITS - EXT_LAYER_BITS;
    localparam logic [15:0] MlMask = (16'd1 << MAIN_LAYER_BITS) - 16'd1;
    localparam logic [15:0] XlMask = (16'd1 << EXT_LAYER_BITS) - 16'd1;

    logic [obup_pkg::SIZE_BITS-1:0]   acc_reg, acc_next;
    logic [7:0]                       hdr_reg, hdr_next;
    logic [obup_pkg::SHIFT_BITS-1:0]  shift_amt;
    logic [obup_pkg::PART_BITS-1:0]   part;
    logic                             emit_hdr;
    logic                             emit_corrupt;
    logic [7:0]                       hdr_byte;
    logic [7:0]                       ext_byte;
    logic [1:0]                       hdr_len;
    logic [15:0]                      ext_win;
    logic [15:0]                      ml_wide;
    logic [15:0]                      xl_wide;
    logic                             ext_flag;
    logic [obup_pkg::TYPE_BITS-1:0]   unit_type;
    logic                             too_short;

    // One event is taken whenever a result could be stored.
    assign ev_pop = !ev_empty && !res_full;

    assign shift_amt = obup_pkg::SHIFT_BITS'(ev.cnt) * obup_pkg::SHIFT_BITS'(7);
    assign part      = {{(obup_pkg::PART_BITS - 7){1'b0}}, ev.data[6:0]} << shift_amt;

    // Event decode and state update.
    always_comb
    begin
        acc_next     = acc_reg;
        hdr_next     = hdr_reg;
        emit_hdr     = 1'b0;
        emit_corrupt = 1'b0;
        hdr_byte     = ev.data;
        ext_byte     = 8'h00;
        hdr_len      = 2'd1;
        case (ev.kind)
            obup_pkg::EV_SIZE:
            begin
                acc_next = ((ev.cnt == '0) ? '0 : acc_reg)
                           | part[obup_pkg::SIZE_BITS-1:0];
            end
            obup_pkg::EV_HDR_SAVE:
            begin
                hdr_next = ev.data;
            end
            obup_pkg::EV_HDR_FINAL:
            begin
                emit_hdr = 1'b1;
            end
            obup_pkg::EV_EXT:
            begin
                hdr_byte = hdr_reg;
                ext_byte = ev.data;
                hdr_len  = 2'd2;
                emit_hdr = 1'b1;
            end
            obup_pkg::EV_CORRUPT:
            begin
                emit_corrupt = 1'b1;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Header field extraction; layer bits past the extension byte read zero.
    assign ext_flag  = hdr_byte[7];
    assign unit_type = hdr_byte[obup_pkg::TYPE_MSB -: obup_pkg::TYPE_BITS];
    assign ext_win   = {ext_byte, 8'h00};
    assign ml_wide   = (ext_win >> MlShift) & MlMask;
    assign xl_wide   = (ext_win >> XlShift) & XlMask;
    assign too_short = (acc_reg < obup_pkg::SIZE_BITS'(hdr_len));

    // Result assembly.
    always_comb
    begin
        res      = '0;
        res_push = ev_pop && (emit_hdr || emit_corrupt);
        if (emit_corrupt || too_short)
        begin
            res.status = obup_pkg::ST_CORRUPT;
        end
        else
        begin
            res.status            = obup_pkg::ST_OK;
            res.extension_present = ext_flag;
            res.unit_type         = unit_type;
            res.temporal_layer    = hdr_byte[obup_pkg::TL_LSB +: obup_pkg::TEMPORAL_BITS];
            if (ext_flag)
            begin
                res.main_layer     = ml_wide[obup_pkg::ML_OUT_BITS-1:0];
                res.extended_layer = xl_wide[obup_pkg::XL_OUT_BITS-1:0];
            end
            else if (unit_type == global_type)
            begin
                res.extended_layer = global_xlayer;
            end
            res.payload_length = acc_reg - obup_pkg::SIZE_BITS'(hdr_len);
            res.consumed_count = ev.cnt + obup_pkg::COUNT_BITS'(hdr_len);
        end
    end

    // Size value and saved header byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            hdr_reg <= '0;
        end
        else if (ev_pop)
        begin
            acc_reg <= acc_next;
            hdr_reg <= hdr_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/obu_size_and_header_parser.sv
// ============================================================================
// obu_size_and_header_parser
// Parses the leading size field and header bytes of each coded-video unit.
// ============================================================================
// The parser takes one byte per clock cycle. A front end classifies every
// byte against the parse phase and flags size-field errors, a two-entry
// event queue carries the classified bytes to a back end that accumulates
// the size value and builds the header result, and a two-entry result queue
// holds results until they are popped. The event of the byte that completes
// the header (or shows the unit to be corrupt) goes through the event queue
// and the back end into the result queue, whose head is the result port;
// throughput is one byte per cycle as long as results are popped, and the
// input reports full once both queues have backed up.
// Configuration writes are taken in any cycle and should only be issued
// while no unit is in flight.
`default_nettype none

module obu_size_and_header_parser #(
    parameter int MAIN_LAYER_BITS = obup_pkg::MAIN_LAYER_BITS_DEF,
    parameter int EXT_LAYER_BITS  = obup_pkg::EXT_LAYER_BITS_DEF,
    parameter int MAX_SIZE_BYTES  = obup_pkg::MAX_SIZE_BYTES_DEF,
    parameter int QUEUE_DEPTH     = obup_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  obup_pkg::in_t                             item,
    output logic                                      empty,
    input  wire logic                                 pop,
    output obup_pkg::out_t                            result,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [obup_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [obup_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int EvW  = $bits(obup_pkg::ev_t);
    localparam int ResW = $bits(obup_pkg::out_t);

    logic [obup_pkg::TYPE_BITS-1:0]   global_type_reg;
    logic [obup_pkg::XL_OUT_BITS-1:0] global_xlayer_reg;
    logic                             accept;
    logic                             ev_push;
    obup_pkg::ev_t                    ev_wr;
    logic [EvW-1:0]                   ev_rd_bits;
    obup_pkg::ev_t                    ev_rd;
    logic                             ev_full;
    logic                             ev_empty;
    logic                             ev_pop;
    logic                             res_push;
    obup_pkg::out_t                   res_wr;
    logic [ResW-1:0]                  res_rd_bits;
    logic                             res_full;

    // Configuration registers; cfg_ready is tied high, so every write is taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_type_reg   <= obup_pkg::GLOBAL_TYPE_RST;
            global_xlayer_reg <= obup_pkg::GLOBAL_XLAYER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                obup_pkg::CFG_GLOBAL_TYPE:   global_type_reg   <= cfg_data;
                obup_pkg::CFG_GLOBAL_XLAYER: global_xlayer_reg <= cfg_data;
                default:                     global_type_reg   <= global_type_reg;
            endcase
        end
    end

    // Input transaction handshake.
    assign full   = ev_full;
    assign accept = push && !ev_full;

    obup_front #(
        .MAX_SIZE_BYTES (MAX_SIZE_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .ev_push (ev_push),
        .ev      (ev_wr)
    );

    // Event queue between front and back.
    obup_fifo #(
        .WIDTH (EvW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ev_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (ev_push),
        .wr_data (ev_wr),
        .full    (ev_full),
        .pop     (ev_pop),
        .rd_data (ev_rd_bits),
        .empty   (ev_empty)
    );

    assign ev_rd = obup_pkg::ev_t'(ev_rd_bits);

    obup_back #(
        .MAIN_LAYER_BITS (MAIN_LAYER_BITS),
        .EXT_LAYER_BITS  (EXT_LAYER_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev            (ev_rd),
        .ev_empty      (ev_empty),
        .ev_pop        (ev_pop),
        .global_type   (global_type_reg),
        .global_xlayer (global_xlayer_reg),
        .res_full      (res_full),
        .res_push      (res_push),
        .res           (res_wr)
    );

    // Result queue toward the consumer.
    obup_fifo #(
        .WIDTH (ResW),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_bits),
        .empty   (empty)
    );

    assign result = obup_pkg::out_t'(res_rd_bits);

endmodule

`default_nettype wire

FILE: tb/obu_size_and_header_parser_test.sv
// ----------------------------------------------------------------------------
// obu_size_and_header_parser_test
// Self-checking testbench for the unit size-and-header parser. Directed units
// hit every error path of the size field and header. Random units then run
// under several global-layer settings, with random stalls on both queues.
// A local predictor tracks the parse state and queues the expected results.
// ----------------------------------------------------------------------------
module obu_size_and_header_parser_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 260;

    // An index that maps to no register; writes to it must change nothing.
    localparam logic [obup_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    // Parse phases of the local predictor.
    typedef enum logic [2:0] {
        WAIT_START,
        IN_SIZE,
        IN_HEADER,
        IN_EXT,
        HEADER_DONE
    } parse_phase_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           push = 1'b0;
    logic           full;
    obup_pkg::in_t  item = '0;
    logic           empty;
    logic           pop = 1'b0;
    obup_pkg::out_t result;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [obup_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [obup_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    // Predictor state and its copy of the configuration.
    parse_phase_t phase = WAIT_START;
    logic [32:0] size_acc = '0;
    int          size_bytes = 0;
    logic [7:0]  hdr_byte = '0;
    logic [4:0]  glob_type = obup_pkg::GLOBAL_TYPE_RST;
    logic [4:0]  glob_xlayer = obup_pkg::GLOBAL_XLAYER_RST;

    obup_pkg::out_t pending_results[$];
    obup_pkg::in_t  unit_q[$];
    int   fail_count = 0;
    int   quiet_cycles = 0;
    int   unit_bytes_sent = 0;
    int   pop_wait = 0;
    bit   steady = 1'b0;

    obu_size_and_header_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A corrupt unit reports status only and sends the parser back to idle.
    task automatic expect_corrupt();
        obup_pkg::out_t res;
        res = '0;
        res.status = obup_pkg::ST_CORRUPT;
        pending_results.push_back(res);
        phase = WAIT_START;
    endtask

    // Builds the header result once the header (and extension) is complete.
    task automatic expect_header(input int hdr_len, input logic [7:0] ext_byte);
        obup_pkg::out_t res;
        res = '0;
        res.status            = obup_pkg::ST_OK;
        res.extension_present = hdr_byte[7];
        res.unit_type         = hdr_byte[6:2];
        res.temporal_layer    = hdr_byte[1:0];
        if (hdr_byte[7])
        begin
            res.main_layer     = ext_byte[7:5];
            res.extended_layer = ext_byte[4:0];
        end
        else if (hdr_byte[6:2] == glob_type)
        begin
            res.extended_layer = glob_xlayer;
        end
        if (size_acc < 33'(hdr_len))
        begin
            expect_corrupt();
        end
        else
        begin
            res.payload_length = size_acc[31:0] - 32'(hdr_len);
            res.consumed_count = 4'(size_bytes + hdr_len);
            pending_results.push_back(res);
            phase = HEADER_DONE;
        end
    endtask

    // Advances the predicted parse by one accepted byte.
    task automatic track_byte(input obup_pkg::in_t it);
        logic [63:0] part;
        if (it.start_req)
        begin
            phase      = IN_SIZE;
            size_acc   = '0;
            size_bytes = 0;
            hdr_byte   = '0;
        end
        case (phase)
            IN_SIZE:
            begin
                part = {57'd0, it.data_byte[6:0]} << (7 * size_bytes);
                size_bytes++;
                size_acc[31:0] = size_acc[31:0] | part[31:0];
                if (part[63:32] != '0)
                    size_acc[32] = 1'b1;
                if (it.data_byte[7])
                begin
                    if (it.last_byte || size_bytes >= obup_pkg::MAX_SIZE_BYTES_DEF)
                        expect_corrupt();
                end
                else if (size_acc[32] || it.last_byte)
                begin
                    expect_corrupt();
                end
                else
                begin
                    phase = IN_HEADER;
                end
            end
            IN_HEADER:
            begin
                hdr_byte = it.data_byte;
                if (it.data_byte[7])
                begin
                    if (it.last_byte)
                        expect_corrupt();
                    else
                        phase = IN_EXT;
                end
                else
                begin
                    expect_header(1, 8'h00);
                end
            end
            IN_EXT: expect_header(2, it.data_byte);
            default: ;
        endcase
    endtask

    // Compares one popped result against the oldest expectation.
    task automatic check_result(input obup_pkg::out_t want, input obup_pkg::out_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.extension_present !== want.extension_present)
        begin
            $error("extension_present: expected %0d, got %0d",
                   want.extension_present, got.extension_present);
            fail_count++;
        end
        if (got.unit_type !== want.unit_type)
        begin
            $error("unit_type: expected %0d, got %0d", want.unit_type, got.unit_type);
            fail_count++;
        end
        if (got.temporal_layer !== want.temporal_layer)
        begin
            $error("temporal_layer: expected %0d, got %0d",
                   want.temporal_layer, got.temporal_layer);
            fail_count++;
        end
        if (got.main_layer !== want.main_layer)
        begin
            $error("main_layer: expected %0d, got %0d", want.main_layer, got.main_layer);
            fail_count++;
        end
        if (got.extended_layer !== want.extended_layer)
        begin
            $error("extended_layer: expected %0d, got %0d",
                   want.extended_layer, got.extended_layer);
            fail_count++;
        end
        if (got.payload_length !== want.payload_length)
        begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, got.payload_length);
            fail_count++;
        end
        if (got.consumed_count !== want.consumed_count)
        begin
            $error("consumed_count: expected %0d, got %0d",
                   want.consumed_count, got.consumed_count);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: every transaction is seen at the rising edge. The watchdog
    // counts cycles in which nothing at all is accepted.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        obup_pkg::out_t want;
        bit             moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    obup_pkg::CFG_GLOBAL_TYPE:   glob_type = cfg_data;
                    obup_pkg::CFG_GLOBAL_XLAYER: glob_xlayer = cfg_data;
                    default: ;
                endcase
                moved = 1'b1;
            end
            if (push && !full)
            begin
                track_byte(item);
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    $error("result with no expectation waiting: %p", result);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_result(want, result);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: pop stalls in random bursts unless the run is steady.
    always @(negedge clk)
    begin
        if (pop_wait > 0)
        begin
            pop_wait <= pop_wait - 1;
            pop <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 7) == 0)
        begin
            pop_wait <= $urandom_range(1, 10) - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one byte, after an optional gap, and returns at the accepting edge.
    task automatic send_byte(input obup_pkg::in_t it);
        @(negedge clk);
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
    endtask

    // A byte with no start mark; the parser ignores it when idle or done.
    task automatic noise_byte(input logic [7:0] b);
        obup_pkg::in_t it;
        it = '0;
        it.data_byte = b;
        it.last_byte = 1'($urandom_range(0, 1));
        send_byte(it);
    endtask

    // Appends a byte to the unit being built; the first one carries start.
    task automatic add_byte(input logic [7:0] b);
        obup_pkg::in_t it;
        it = '0;
        it.data_byte = b;
        it.start_req = (unit_q.size() == 0);
        unit_q.push_back(it);
    endtask

    // Sends the built unit, optionally marking its final byte as the last.
    task automatic flush_unit(input bit mark_last);
        if (unit_q.size() != 0 && mark_last)
            unit_q[unit_q.size() - 1].last_byte = 1'b1;
        foreach (unit_q[k])
            send_byte(unit_q[k]);
        unit_bytes_sent += unit_q.size();
        unit_q.delete();
    endtask

    // Sends n bytes given first-byte-most-significant in seq.
    task automatic send_directed(input int n, input logic [63:0] seq, input bit mark_last);
        for (int k = n - 1; k >= 0; k--)
            add_byte(seq[8 * k +: 8]);
        flush_unit(mark_last);
    endtask

    // Stops driving, waits for every expected result and for the pipeline
    // to settle, so that the parser is idle.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write transaction; returns at the accepting edge.
    task automatic write_reg(input logic [obup_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [obup_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Builds one random unit: mostly well formed, the rest broken or noise.
    task automatic send_random_unit();
        logic [63:0] value;
        logic [7:0]  hdr;
        int nsize;
        int minlen;
        int kind;
        int cut;
        case ($urandom_range(0, 9))
            0: value = 64'($urandom_range(0, 2));
            1: value = 64'hFFFF_FFFF - $urandom_range(0, 2);
            2: value = {$urandom, $urandom} & 64'h00FF_FFFF_FFFF_FFFF;
            3: value = {32'd0, $urandom};
            default: value = 64'($urandom_range(0, 300));
        endcase
        minlen = 1;
        while (minlen < obup_pkg::MAX_SIZE_BYTES_DEF && (value >> (7 * minlen)) != 0)
            minlen++;
        nsize = ($urandom_range(0, 3) == 0) ?
                $urandom_range(minlen, obup_pkg::MAX_SIZE_BYTES_DEF) : minlen;
        for (int k = 0; k < nsize; k++)
            add_byte({(k < nsize - 1), 7'(value >> (7 * k))});
        hdr = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0)
            hdr[6:2] = glob_type;
        add_byte(hdr);
        if (hdr[7])
            add_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3))
            add_byte(8'($urandom_range(0, 255)));

        kind = $urandom_range(0, 11);
        case (kind)
            // Unit cut short and marked as ending there.
            0:
            begin
                cut = $urandom_range(1, unit_q.size());
                while (unit_q.size() > cut)
                    void'(unit_q.pop_back());
                flush_unit(1'b1);
            end
            // Size field that never ends within the allowed length.
            1:
            begin
                unit_q.delete();
                repeat ($urandom_range(obup_pkg::MAX_SIZE_BYTES_DEF,
                                       obup_pkg::MAX_SIZE_BYTES_DEF + 1))
                    add_byte(8'h80 | 8'($urandom_range(0, 127)));
                flush_unit(1'($urandom_range(0, 1)));
            end
            // Unit abandoned part way; the next start drops it.
            2:
            begin
                cut = $urandom_range(1, unit_q.size());
                while (unit_q.size() > cut)
                    void'(unit_q.pop_back());
                flush_unit(1'b0);
            end
            // Stray bytes with no start.
            3:
            begin
                unit_q.delete();
                repeat ($urandom_range(1, 3))
                    noise_byte(8'($urandom_range(0, 255)));
            end
            default: flush_unit($urandom_range(0, 3) != 0);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Unextended type 0 right after reset takes the reset global layer id.
    task automatic test_reset_globals();
        send_directed(2, 64'h02_00, 1'b1);
    endtask

    // Every way the size field can make a unit corrupt.
    task automatic test_size_errors();
        send_directed(1, 64'h80, 1'b1);                   // truncated field
        noise_byte(8'h55);                                // ignored while idle
        send_directed(8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);  // field too long
        send_directed(5, 64'h80_80_80_80_10, 1'b0);       // value of 2^32
        send_directed(1, 64'h05, 1'b1);                   // no header byte
    endtask

    // Header decode, extension handling and header-length checks.
    task automatic test_header_decode();
        send_directed(2, 64'h03_80, 1'b1);                // extension missing
        send_directed(3, 64'h01_80_00, 1'b0);             // size below two
        send_directed(3, 64'h01_04_AA, 1'b1);             // exact length, byte after done
    endtask

    // A start in the middle of a unit drops the unit in progress.
    task automatic test_restart();
        send_directed(1, 64'h85, 1'b0);
        send_directed(3, 64'h0A_FF_FF, 1'b0);
    endtask

    // Random traffic under one global-layer setting.
    task automatic test_random_phase(input logic [4:0] gtype, input logic [4:0] gxl,
                                     input bit no_idle, input bit touch_unmapped);
        int first;
        drain();
        write_reg(obup_pkg::CFG_GLOBAL_TYPE, gtype);
        write_reg(obup_pkg::CFG_GLOBAL_XLAYER, gxl);
        if (touch_unmapped)
            write_reg(CFG_UNMAPPED, 5'($urandom_range(0, 31)));
        @(negedge clk);
        cfg_valid <= 1'b0;
        steady = no_idle;
        first = unit_bytes_sent;
        while (unit_bytes_sent - first < PHASE_BYTES)
            send_random_unit();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_globals();
        test_size_errors();
        test_header_decode();
        test_restart();

        test_random_phase(5'd31, 5'd0, 1'b0, 1'b0);
        test_random_phase(5'd0, 5'd31, 1'b0, 1'b1);
        test_random_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          1'b0, 1'b0);
        test_random_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          1'b0, 1'b0);
        test_random_phase(5'd17, 5'd10, 1'b1, 1'b0);

        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/obup_pkg.sv
src/obup_fifo.sv
src/obup_front.sv
src/obup_back.sv
src/obu_size_and_header_parser.sv
tb/obu_size_and_header_parser_test.sv
